@@ design/jcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared widths, codes and word types of the joystick calibrate-and-scale block.
// ----------------------------------------------------------------------------
package jcs_pkg;

    localparam int SAMPLE_BITS = 12;
    // extremes and centre hold one more bit: highest resets to 2^SAMPLE_BITS
    localparam int EXT_BITS    = SAMPLE_BITS + 1;
    // len * 100 fits in SAMPLE_BITS + 7 bits
    localparam int DIV_BITS    = SAMPLE_BITS + 7;
    localparam int CNT_BITS    = $clog2(DIV_BITS + 1);

    localparam logic [2:0] MAX_SHIFT      = 3'd5;
    localparam logic [7:0] DEADBAND_RESET = 8'd15;
    localparam logic [6:0] EFFORT_FULL    = 7'd100;

    localparam logic [EXT_BITS-1:0] LOWEST_RESET  = '0;
    localparam logic [EXT_BITS-1:0] HIGHEST_RESET = EXT_BITS'(1) << SAMPLE_BITS;
    localparam logic [EXT_BITS-1:0] CENTRE_RESET  = EXT_BITS'(1) << (SAMPLE_BITS - 1);

    // register indexes on the config port
    localparam logic REG_DPI_SHIFT = 1'b0;
    localparam logic REG_DEADBAND  = 1'b1;

    // long press tally codes
    localparam logic [2:0] PRESS_START  = 3'd2;
    localparam logic [2:0] PRESS_CENTRE = 3'd3;
    localparam logic [2:0] PRESS_END    = 3'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
        logic                   long_press;
    } in_word_t;

    typedef struct packed {
        logic [5:0] cursor_x_low;
        logic [5:0] cursor_x_high;
        logic [5:0] cursor_y_low;
        logic [5:0] cursor_y_high;
        logic [6:0] effort_x_low;
        logic [6:0] effort_x_high;
        logic [6:0] effort_y_low;
        logic [6:0] effort_y_high;
        logic       calibrating;
        logic [2:0] press_count;
    } out_word_t;

    typedef struct packed {
        logic load_in;
        logic update;
        logic setup;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [5:0] cursor_low;
        logic [5:0] cursor_high;
        logic [6:0] effort_low;
        logic [6:0] effort_high;
    } axis_result_t;

endpackage

@@ design/jcs_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_divider
// Restoring divider, one quotient bit per step; load sets operands.
// ----------------------------------------------------------------------------
module jcs_divider
(
    input  logic                         clk,
    input  logic                         load,
    input  logic                         step,
    input  logic [jcs_pkg::DIV_BITS-1:0] dividend,
    input  logic [jcs_pkg::EXT_BITS-1:0] divisor,
    output logic [jcs_pkg::DIV_BITS-1:0] quotient
);

    logic [jcs_pkg::EXT_BITS-1:0] rem_reg, rem_next;
    logic [jcs_pkg::DIV_BITS-1:0] quo_reg, quo_next;
    logic [jcs_pkg::EXT_BITS-1:0] divisor_reg;
    logic [jcs_pkg::EXT_BITS:0]   partial;
    logic [jcs_pkg::EXT_BITS:0]   diff;
    logic                         fits;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[jcs_pkg::DIV_BITS-1]};
        diff     = partial - {1'b0, divisor_reg};
        fits     = partial >= {1'b0, divisor_reg};
        rem_next = fits ? diff[jcs_pkg::EXT_BITS-1:0] : partial[jcs_pkg::EXT_BITS-1:0];
        quo_next = {quo_reg[jcs_pkg::DIV_BITS-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

@@ design/jcs_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_axis
// One axis: distance, range and deadband test, then cursor and effort
// scaling through two dividers.
// ----------------------------------------------------------------------------
module jcs_axis
(
    input  logic                            clk,
    input  logic                            setup,
    input  logic                            div_step,
    input  logic [jcs_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [jcs_pkg::EXT_BITS-1:0]    lowest,
    input  logic [jcs_pkg::EXT_BITS-1:0]    highest,
    input  logic [jcs_pkg::EXT_BITS-1:0]    centre,
    input  logic [2:0]                      shift,
    input  logic [7:0]                      deadband,
    output jcs_pkg::axis_result_t           result
);

    logic [jcs_pkg::EXT_BITS-1:0] s_ext;
    logic                         low_side;
    logic [jcs_pkg::EXT_BITS-1:0] len;
    logic [jcs_pkg::EXT_BITS-1:0] range;
    logic [jcs_pkg::EXT_BITS-1:0] step_size;
    logic [jcs_pkg::DIV_BITS-1:0] len_x100;
    logic                         in_band;

    logic       low_side_reg;
    logic       in_band_reg;
    logic       step_zero_reg;
    logic       range_zero_reg;
    logic       len_zero_reg;
    logic [5:0] dpi_reg;

    logic [jcs_pkg::DIV_BITS-1:0] cur_q;
    logic [jcs_pkg::DIV_BITS-1:0] eff_q;
    logic [5:0]                   cursor;
    logic [6:0]                   effort;

    always_comb
    begin
        s_ext    = {1'b0, sample};
        low_side = s_ext < centre;
        len      = low_side ? (centre - s_ext) : (s_ext - centre);
        // a negative range counts as empty
        if (low_side)
            range = (centre > lowest) ? (centre - lowest) : '0;
        else
            range = (highest > centre) ? (highest - centre) : '0;
        step_size = range >> shift;
        in_band   = len <= {{(jcs_pkg::EXT_BITS-8){1'b0}}, deadband};
        len_x100  = jcs_pkg::DIV_BITS'(len) * jcs_pkg::DIV_BITS'(jcs_pkg::EFFORT_FULL);
    end

    always_ff @(posedge clk)
    begin
        if (setup)
        begin
            low_side_reg   <= low_side;
            in_band_reg    <= in_band;
            step_zero_reg  <= step_size == '0;
            range_zero_reg <= range == '0;
            len_zero_reg   <= len == '0;
            dpi_reg        <= 6'd1 << shift;
        end
    end

    jcs_divider u_cursor_div
    (
        .clk      (clk),
        .load     (setup),
        .step     (div_step),
        .dividend (jcs_pkg::DIV_BITS'(len)),
        .divisor  (step_size),
        .quotient (cur_q)
    );

    jcs_divider u_effort_div
    (
        .clk      (clk),
        .load     (setup),
        .step     (div_step),
        .dividend (len_x100),
        .divisor  (range),
        .quotient (eff_q)
    );

    always_comb
    begin
        if (step_zero_reg || (cur_q >= jcs_pkg::DIV_BITS'(dpi_reg)))
            cursor = dpi_reg;
        else
            cursor = cur_q[5:0] + 6'd1;

        if (range_zero_reg)
            effort = len_zero_reg ? 7'd0 : jcs_pkg::EFFORT_FULL;
        else if (eff_q > jcs_pkg::DIV_BITS'(jcs_pkg::EFFORT_FULL))
            effort = jcs_pkg::EFFORT_FULL;
        else
            effort = eff_q[6:0];

        result.cursor_low  = (low_side_reg && !in_band_reg) ? cursor : 6'd0;
        result.cursor_high = (!low_side_reg && !in_band_reg) ? cursor : 6'd0;
        result.effort_low  = low_side_reg ? effort : 7'd0;
        result.effort_high = low_side_reg ? 7'd0 : effort;
    end

endmodule

@@ design/jcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_datapath
// Config registers, calibration state, both axes and the output word.
// ----------------------------------------------------------------------------
module jcs_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  jcs_pkg::ctrl_cmd_t cmd,
    input  jcs_pkg::in_word_t  in_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output jcs_pkg::out_word_t out_data
);

    localparam int EB = jcs_pkg::EXT_BITS;

    logic [2:0] dpi_shift_reg;
    logic [7:0] deadband_reg;

    jcs_pkg::in_word_t  in_reg;
    jcs_pkg::out_word_t out_reg;

    logic [EB-1:0] x_lowest_reg, x_lowest_next;
    logic [EB-1:0] x_highest_reg, x_highest_next;
    logic [EB-1:0] x_centre_reg, x_centre_next;
    logic [EB-1:0] y_lowest_reg, y_lowest_next;
    logic [EB-1:0] y_highest_reg, y_highest_next;
    logic [EB-1:0] y_centre_reg, y_centre_next;
    logic [2:0]    tally_reg, tally_next;
    logic          calib_reg, calib_next;

    logic [EB-1:0] xs;
    logic [EB-1:0] ys;
    logic [2:0]    shift;

    jcs_pkg::axis_result_t x_res;
    jcs_pkg::axis_result_t y_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpi_shift_reg <= '0;
            deadband_reg  <= jcs_pkg::DEADBAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jcs_pkg::REG_DPI_SHIFT: dpi_shift_reg <= cfg_data[2:0];
                jcs_pkg::REG_DEADBAND:  deadband_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
    end

    assign xs    = {1'b0, in_reg.x_sample};
    assign ys    = {1'b0, in_reg.y_sample};
    assign shift = (dpi_shift_reg > jcs_pkg::MAX_SHIFT) ? jcs_pkg::MAX_SHIFT : dpi_shift_reg;

    // press handling first, then widening with the updated extremes
    always_comb
    begin
        x_lowest_next  = x_lowest_reg;
        x_highest_next = x_highest_reg;
        x_centre_next  = x_centre_reg;
        y_lowest_next  = y_lowest_reg;
        y_highest_next = y_highest_reg;
        y_centre_next  = y_centre_reg;
        tally_next     = tally_reg;
        calib_next     = calib_reg;

        if (in_reg.long_press)
        begin
            tally_next = tally_reg + 3'd1;
            if (tally_next == jcs_pkg::PRESS_START)
            begin
                calib_next     = 1'b1;
                x_lowest_next  = xs;
                x_highest_next = xs;
                y_lowest_next  = ys;
                y_highest_next = ys;
            end
            if (tally_next == jcs_pkg::PRESS_CENTRE)
            begin
                x_centre_next = xs;
                y_centre_next = ys;
            end
            if (tally_next == jcs_pkg::PRESS_END)
            begin
                calib_next = 1'b0;
                tally_next = 3'd0;
            end
        end

        if (calib_next)
        begin
            if (xs < x_lowest_next)  x_lowest_next  = xs;
            if (xs > x_highest_next) x_highest_next = xs;
            if (ys < y_lowest_next)  y_lowest_next  = ys;
            if (ys > y_highest_next) y_highest_next = ys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lowest_reg  <= jcs_pkg::LOWEST_RESET;
            x_highest_reg <= jcs_pkg::HIGHEST_RESET;
            x_centre_reg  <= jcs_pkg::CENTRE_RESET;
            y_lowest_reg  <= jcs_pkg::LOWEST_RESET;
            y_highest_reg <= jcs_pkg::HIGHEST_RESET;
            y_centre_reg  <= jcs_pkg::CENTRE_RESET;
            tally_reg     <= '0;
            calib_reg     <= 1'b0;
        end
        else if (cmd.update)
        begin
            x_lowest_reg  <= x_lowest_next;
            x_highest_reg <= x_highest_next;
            x_centre_reg  <= x_centre_next;
            y_lowest_reg  <= y_lowest_next;
            y_highest_reg <= y_highest_next;
            y_centre_reg  <= y_centre_next;
            tally_reg     <= tally_next;
            calib_reg     <= calib_next;
        end
    end

    jcs_axis u_x_axis
    (
        .clk      (clk),
        .setup    (cmd.setup),
        .div_step (cmd.div_step),
        .sample   (in_reg.x_sample),
        .lowest   (x_lowest_reg),
        .highest  (x_highest_reg),
        .centre   (x_centre_reg),
        .shift    (shift),
        .deadband (deadband_reg),
        .result   (x_res)
    );

    jcs_axis u_y_axis
    (
        .clk      (clk),
        .setup    (cmd.setup),
        .div_step (cmd.div_step),
        .sample   (in_reg.y_sample),
        .lowest   (y_lowest_reg),
        .highest  (y_highest_reg),
        .centre   (y_centre_reg),
        .shift    (shift),
        .deadband (deadband_reg),
        .result   (y_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.cursor_x_low  <= x_res.cursor_low;
            out_reg.cursor_x_high <= x_res.cursor_high;
            out_reg.cursor_y_low  <= y_res.cursor_low;
            out_reg.cursor_y_high <= y_res.cursor_high;
            out_reg.effort_x_low  <= x_res.effort_low;
            out_reg.effort_x_high <= x_res.effort_high;
            out_reg.effort_y_low  <= y_res.effort_low;
            out_reg.effort_y_high <= y_res.effort_high;
            out_reg.calibrating   <= calib_reg;
            out_reg.press_count   <= tally_reg;
        end
    end

    assign out_data = out_reg;

endmodule

@@ design/jcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_ctrl
// Sequencer: take a word, update state, run the dividers, post the result.
// ----------------------------------------------------------------------------
module jcs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output jcs_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [jcs_pkg::CNT_BITS-1:0] LAST_STEP =
        jcs_pkg::CNT_BITS'(jcs_pkg::DIV_BITS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [jcs_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                count_next = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + jcs_pkg::CNT_BITS'(1);
                if (count_reg == LAST_STEP)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the previous word has left
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/joystick_calibrate_and_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_calibrate_and_scale
// Steps from input accept to output word: state update, setup, SAMPLE_BITS+7 =
// 19 bit-serial divider steps, finish. in_stall stays high until the finish
// step posts the word, so no new word is taken while one is in work; a waiting
// output word holds only the finish step. Reset clears calibration to full
// range, centre at mid scale, dpi_shift 0, deadband 15.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_scale
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  jcs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output jcs_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    jcs_pkg::ctrl_cmd_t cmd;

    jcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    jcs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
